/* sv/presence_gated_sensor_averager_macros.svh */
// Assertion macros used by the checker file.
`ifndef PRESENCE_GATED_SENSOR_AVERAGER_MACROS_SVH
`define PRESENCE_GATED_SENSOR_AVERAGER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define PGSA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pgsa: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define PGSA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pgsa: next-cycle check failed");

`endif

/* sv/pgsa_pkg.sv */
`timescale 1ns / 1ps

package pgsa_pkg;

    // Window and datapath sizes
    localparam int MAX_SAMPLES = 1024;
    localparam int DATA_W      = 16;
    localparam int CNT_W       = 11;
    localparam int SUM_W       = DATA_W + $clog2(MAX_SAMPLES);
    localparam int TSUM_W      = SUM_W + 1;
    localparam int DIV_STEPS   = DATA_W;
    localparam int STEP_W      = $clog2(DIV_STEPS);
    localparam int NUM_LANES   = 5;

    // Stream widths
    localparam int S_TDATA_W = 88;
    localparam int M_TDATA_W = 96;
    localparam int M_TUSER_W = 3;

    // Input item bit positions in s_tdata
    localparam int IN_PIR   = 0;
    localparam int IN_LUM   = 1;
    localparam int IN_TEMP  = 17;
    localparam int IN_SOIL  = 33;
    localparam int IN_AIRM  = 49;
    localparam int IN_AIRQ  = 65;
    localparam int IN_FLUSH = 81;

    // Result item bit positions in m_tdata
    localparam int OUT_DISP = 0;
    localparam int OUT_LUM  = 1;
    localparam int OUT_TEMP = 17;
    localparam int OUT_SOIL = 33;
    localparam int OUT_AIRM = 49;
    localparam int OUT_AIRQ = 65;
    localparam int OUT_PRES = 81;
    localparam int OUT_CNT  = 82;
    localparam int OUT_END  = OUT_CNT + CNT_W;

    // Divider lane assignment
    localparam int LANE_LUM  = 0;
    localparam int LANE_TEMP = 1;
    localparam int LANE_SOIL = 2;
    localparam int LANE_AIRM = 3;
    localparam int LANE_AIRQ = 4;

    typedef enum logic [1:0] {
        ACT_NONE = 2'd0,
        ACT_ON   = 2'd1,
        ACT_OFF  = 2'd2,
        ACT_ACQ  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic take;
        logic div_step;
        logic emit;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic report_req;
        logic out_free;
    } dp_status_t;

endpackage

/* sv/pgsa_div_lane.sv */
`timescale 1ns / 1ps

module pgsa_div_lane
    import pgsa_pkg::*;
(
    input  logic              clk,
    input  logic              load,
    input  logic              step,
    input  logic [SUM_W-1:0]  dividend,
    input  logic [CNT_W-1:0]  divisor,
    output logic [DATA_W-1:0] quotient
);

    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    diff;
    logic              fits;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        trial = {rem_reg, quo_reg[DATA_W-1]};
        diff  = trial - {1'b0, divisor};
        fits  = (trial >= {1'b0, divisor});
        rem_next = rem_reg;
        quo_next = quo_reg;
        if (load)
        begin
            // The high part is below the divisor since the quotient fits DATA_W bits
            rem_next = {{(CNT_W - (SUM_W - DATA_W)){1'b0}}, dividend[SUM_W-1:DATA_W]};
            quo_next = dividend[DATA_W-1:0];
        end
        else if (step)
        begin
            rem_next = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
            quo_next = {quo_reg[DATA_W-2:0], fits};
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign quotient = quo_reg;

endmodule

/* sv/pgsa_ctrl.sv */
`timescale 1ns / 1ps

module pgsa_ctrl
    import pgsa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                step_next = '0;
                if (s_tvalid)
                begin
                    state_next = status.report_req ? ST_DIV : ST_EMIT;
                end
            end
            ST_DIV:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        s_tready     = 1'b0;
        cmd.take     = 1'b0;
        cmd.div_step = 1'b0;
        cmd.emit     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.take = s_tvalid;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            ST_EMIT:
            begin
                cmd.emit = status.out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

/* sv/pgsa_datapath.sv */
`timescale 1ns / 1ps

module pgsa_datapath
    import pgsa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [M_TUSER_W-1:0] m_tuser,
    input  ctrl_cmd_t            cmd,
    output dp_status_t           status
);

    // Window state
    logic                     prev_pir_reg, prev_pir_next;
    logic                     disp_reg, disp_next;
    logic                     flush_reg, flush_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [SUM_W-1:0]         usum_reg [4];
    logic [SUM_W-1:0]         usum_next [4];
    logic signed [TSUM_W-1:0] tsum_reg, tsum_next;
    logic [CNT_W-1:0]         psum_reg, psum_next;

    // Pending result fields
    action_t                  act_reg, act_next;
    logic                     rep_reg, rep_next;
    logic [CNT_W-1:0]         n_reg, n_next;
    logic                     pres_reg, pres_next;
    logic                     tneg_reg, tneg_next;

    // Output register
    logic                     mvalid_reg, mvalid_next;
    logic [M_TDATA_W-1:0]     mdata_reg, mdata_next;
    logic [M_TUSER_W-1:0]     muser_reg, muser_next;

    // Item fields
    logic                     pir;
    logic                     flush_eff;
    logic                     acquire;
    logic                     report;
    logic                     room;
    logic [DATA_W-1:0]        uin [4];
    logic [DATA_W-1:0]        tin;
    action_t                  action;
    logic                     disp_after;

    // Sums after this item
    logic [SUM_W-1:0]         usum_acc [4];
    logic signed [TSUM_W-1:0] tsum_acc;
    logic [CNT_W-1:0]         psum_acc;
    logic [CNT_W-1:0]         cnt_acc;
    logic [TSUM_W-1:0]        tmag_full;
    logic                     tneg;
    logic [SUM_W-1:0]         lane_in [NUM_LANES];
    logic [DATA_W-1:0]        lane_q [NUM_LANES];
    logic                     div_load;
    logic                     nonzero;
    logic [DATA_W-1:0]        temp_avg;

    assign pir       = s_tdata[IN_PIR];
    assign uin[0]    = s_tdata[IN_LUM  +: DATA_W];
    assign uin[1]    = s_tdata[IN_SOIL +: DATA_W];
    assign uin[2]    = s_tdata[IN_AIRM +: DATA_W];
    assign uin[3]    = s_tdata[IN_AIRQ +: DATA_W];
    assign tin       = s_tdata[IN_TEMP +: DATA_W];
    assign flush_eff = flush_reg | s_tdata[IN_FLUSH];

    // Classify the presence sample against the previous one
    always_comb
    begin
        action     = ACT_ACQ;
        disp_after = disp_reg;
        if (pir && !prev_pir_reg)
        begin
            action     = disp_reg ? ACT_NONE : ACT_ON;
            disp_after = 1'b1;
        end
        else if (!pir && prev_pir_reg)
        begin
            action     = disp_reg ? ACT_OFF : ACT_NONE;
            disp_after = 1'b0;
        end
    end

    assign acquire = (action == ACT_ACQ);
    assign report  = acquire & flush_eff;
    assign room    = (cnt_reg < CNT_W'(MAX_SAMPLES));

    // Accumulate an acquired sample unless the window is full
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            usum_acc[i] = (acquire && room) ? usum_reg[i] + SUM_W'(uin[i]) : usum_reg[i];
        end
        tsum_acc = (acquire && room)
                 ? tsum_reg + {{(TSUM_W - DATA_W){tin[DATA_W-1]}}, tin}
                 : tsum_reg;
        psum_acc = (acquire && room) ? psum_reg + CNT_W'(pir) : psum_reg;
        cnt_acc  = (acquire && room) ? cnt_reg + 1'b1 : cnt_reg;
    end

    // Temperature divides as a magnitude
    assign tneg      = tsum_acc[TSUM_W-1];
    assign tmag_full = tneg ? TSUM_W'(-tsum_acc) : TSUM_W'(tsum_acc);

    assign lane_in[LANE_LUM]  = usum_acc[0];
    assign lane_in[LANE_TEMP] = tmag_full[SUM_W-1:0];
    assign lane_in[LANE_SOIL] = usum_acc[1];
    assign lane_in[LANE_AIRM] = usum_acc[2];
    assign lane_in[LANE_AIRQ] = usum_acc[3];
    assign div_load           = cmd.take & report;

    for (genvar g = 0; g < NUM_LANES; g++)
    begin : g_lane
        pgsa_div_lane u_lane (
            .clk      (clk),
            .load     (div_load),
            .step     (cmd.div_step),
            .dividend (lane_in[g]),
            .divisor  (n_reg),
            .quotient (lane_q[g])
        );
    end

    // Update window state and pending fields on a taken item
    always_comb
    begin
        prev_pir_next = prev_pir_reg;
        disp_next     = disp_reg;
        flush_next    = flush_reg;
        cnt_next      = cnt_reg;
        tsum_next     = tsum_reg;
        psum_next     = psum_reg;
        act_next      = act_reg;
        rep_next      = rep_reg;
        n_next        = n_reg;
        pres_next     = pres_reg;
        tneg_next     = tneg_reg;
        for (int i = 0; i < 4; i++)
        begin
            usum_next[i] = usum_reg[i];
        end
        if (cmd.take)
        begin
            prev_pir_next = pir;
            disp_next     = disp_after;
            act_next      = action;
            rep_next      = report;
            n_next        = cnt_acc;
            pres_next     = ({psum_acc, 1'b0} >= {1'b0, cnt_acc});
            tneg_next     = tneg;
            if (report)
            begin
                flush_next = 1'b0;
                cnt_next   = '0;
                tsum_next  = '0;
                psum_next  = '0;
                for (int i = 0; i < 4; i++)
                begin
                    usum_next[i] = '0;
                end
            end
            else
            begin
                flush_next = flush_eff;
                cnt_next   = cnt_acc;
                tsum_next  = tsum_acc;
                psum_next  = psum_acc;
                for (int i = 0; i < 4; i++)
                begin
                    usum_next[i] = usum_acc[i];
                end
            end
        end
    end

    // Assemble the result item; averages are zero without a report or samples
    assign nonzero  = rep_reg && (n_reg != '0);
    assign temp_avg = tneg_reg ? DATA_W'(-lane_q[LANE_TEMP]) : lane_q[LANE_TEMP];

    always_comb
    begin
        mdata_next = mdata_reg;
        muser_next = muser_reg;
        mvalid_next = mvalid_reg;
        if (m_tready)
        begin
            mvalid_next = 1'b0;
        end
        if (cmd.emit)
        begin
            mvalid_next                     = 1'b1;
            mdata_next                      = '0;
            mdata_next[OUT_DISP]            = disp_reg;
            mdata_next[OUT_LUM  +: DATA_W]  = nonzero ? lane_q[LANE_LUM]  : '0;
            mdata_next[OUT_TEMP +: DATA_W]  = nonzero ? temp_avg          : '0;
            mdata_next[OUT_SOIL +: DATA_W]  = nonzero ? lane_q[LANE_SOIL] : '0;
            mdata_next[OUT_AIRM +: DATA_W]  = nonzero ? lane_q[LANE_AIRM] : '0;
            mdata_next[OUT_AIRQ +: DATA_W]  = nonzero ? lane_q[LANE_AIRQ] : '0;
            mdata_next[OUT_PRES]            = nonzero & pres_reg;
            mdata_next[OUT_CNT +: CNT_W]    = rep_reg ? n_reg : '0;
            muser_next                      = {rep_reg, act_reg};
        end
    end

    assign status.report_req = report;
    assign status.out_free   = !mvalid_reg || m_tready;

    // Control and window state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_pir_reg <= 1'b0;
            disp_reg     <= 1'b0;
            flush_reg    <= 1'b0;
            cnt_reg      <= '0;
            tsum_reg     <= '0;
            psum_reg     <= '0;
            mvalid_reg   <= 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                usum_reg[i] <= '0;
            end
        end
        else
        begin
            prev_pir_reg <= prev_pir_next;
            disp_reg     <= disp_next;
            flush_reg    <= flush_next;
            cnt_reg      <= cnt_next;
            tsum_reg     <= tsum_next;
            psum_reg     <= psum_next;
            mvalid_reg   <= mvalid_next;
            for (int i = 0; i < 4; i++)
            begin
                usum_reg[i] <= usum_next[i];
            end
        end
    end

    // Payload holding registers
    always_ff @(posedge clk)
    begin
        act_reg   <= act_next;
        rep_reg   <= rep_next;
        n_reg     <= n_next;
        pres_reg  <= pres_next;
        tneg_reg  <= tneg_next;
        mdata_reg <= mdata_next;
        muser_reg <= muser_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = muser_reg;

endmodule

/* sv/presence_gated_sensor_averager.sv */
`timescale 1ns / 1ps

// Presence-gated sensor averager. Each input item carries a presence sample,
// five environment readings and a flush request; each produces one result item.
// A presence edge switches the display on or off; an unchanged sample adds the
// readings into a window of up to 1024 samples, and a pending flush then reports
// the truncated window averages and clears the window. An item without a report
// goes through the emit state back to idle; an item that reports first passes
// through the divide state, where five parallel radix-2 divider lanes produce
// one quotient bit per cycle of a 16-bit quotient. A finished result waits in
// the output register while the next item is accepted.

module presence_gated_sensor_averager
    import pgsa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // pir_sample, luminosity, temperature, soil_moisture, air_moisture,
    // air_quality, flush_request, zero pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // display_on, avg_luminosity, avg_temperature, avg_soil_moisture,
    // avg_air_moisture, avg_air_quality, avg_presence, samples_averaged, zero pad
    output logic [M_TDATA_W-1:0] m_tdata,
    // action_taken, report_valid
    output logic [M_TUSER_W-1:0] m_tuser
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    pgsa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pgsa_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cmd      (cmd),
        .status   (status)
    );

endmodule

/* sv/pgsa_checker.sv */
`timescale 1ns / 1ps

`include "presence_gated_sensor_averager_macros.svh"

module pgsa_checker
    import pgsa_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [M_TUSER_W-1:0] m_tuser
);

    // Hold a stalled result item
    `PGSA_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // No report means zero averages and count
    `PGSA_ASSERT_IMPLY(a_no_report_zero, clk, rst_n, m_tvalid && !m_tuser[2], m_tdata[OUT_END-1:OUT_LUM] == '0)

    // Only an acquisition reports
    `PGSA_ASSERT_IMPLY(a_report_acq, clk, rst_n, m_tvalid && m_tuser[2], m_tuser[1:0] == ACT_ACQ)

    // Display state follows a switching action
    `PGSA_ASSERT_IMPLY(a_disp_action, clk, rst_n, m_tvalid && (m_tuser[1:0] == ACT_ON || m_tuser[1:0] == ACT_OFF), m_tdata[OUT_DISP] == (m_tuser[1:0] == ACT_ON))

    // Window never exceeds its limit
    `PGSA_ASSERT_IMPLY(a_cnt_limit, clk, rst_n, m_tvalid, m_tdata[OUT_CNT +: CNT_W] <= CNT_W'(MAX_SAMPLES))

endmodule

bind presence_gated_sensor_averager pgsa_checker u_pgsa_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
